// ===== hw/rtl/utf8s_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and lookup functions for the utf8 slug generator.
// ----------------------------------------------------------------------------
package utf8s_pkg;

   localparam int LengthBitsDefault = 24;
   localparam int SlugLenBits       = 24;
   localparam int CharBits          = 7;
   localparam int ResultSlots       = 3;

   localparam logic [7:0] LeadMin     = 8'hC2;
   localparam logic [7:0] LeadMax     = 8'hF4;
   localparam logic [7:0] Lead3Min    = 8'hE0;
   localparam logic [7:0] Lead4Min    = 8'hF0;
   localparam logic [7:0] LeadE0      = 8'hE0;
   localparam logic [7:0] LeadEd      = 8'hED;
   localparam logic [7:0] LeadF0      = 8'hF0;
   localparam logic [7:0] LeadF4      = 8'hF4;
   localparam logic [7:0] LeadLatin1  = 8'hC3;
   localparam logic [7:0] ContA0      = 8'hA0;
   localparam logic [7:0] Cont90      = 8'h90;
   localparam logic [7:0] Cont8f      = 8'h8F;
   localparam logic [7:0] SepReset    = 8'h2D;
   localparam logic [6:0] SepDefault  = 7'h2D;

   typedef enum logic [0:0] {
      CSR_SEPARATOR  = 1'b0,
      CSR_LOWER_CASE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] lead;
      logic [1:0] expect_cnt;
      logic [1:0] seen;
      logic       pending;
   } stream_state_type;

   typedef struct packed {
      logic [ResultSlots-1:0][CharBits-1:0] chars;
      logic [1:0]                           nchar;
   } dec_result_type;

   typedef struct packed {
      logic [CharBits-1:0] c0;
      logic [CharBits-1:0] c1;
      logic [1:0]          count;
   } fold_type;

   function automatic fold_type fold_latin1(input logic [5:0] idx);
      fold_type f;
      f.c0    = 7'h00;
      f.c1    = 7'h00;
      f.count = 2'd1;
      case (idx[4:0])
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: f.c0 = 7'h61;
         5'd6: begin
            f.c0 = 7'h61;
            f.c1 = 7'h65;
            f.count = 2'd2;
         end
         5'd7: f.c0 = 7'h63;
         5'd8, 5'd9, 5'd10, 5'd11: f.c0 = 7'h65;
         5'd12, 5'd13, 5'd14, 5'd15: f.c0 = 7'h69;
         5'd16: f.c0 = 7'h64;
         5'd17: f.c0 = 7'h6E;
         5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24: f.c0 = 7'h6F;
         5'd23: f.count = 2'd0;
         5'd25, 5'd26, 5'd27, 5'd28: f.c0 = 7'h75;
         5'd29: f.c0 = 7'h79;
         5'd30: begin
            f.c0 = 7'h74;
            f.c1 = 7'h68;
            f.count = 2'd2;
         end
         5'd31: begin
            if (idx[5]) begin
               f.c0 = 7'h79;
            end else begin
               f.c0 = 7'h73;
               f.c1 = 7'h73;
               f.count = 2'd2;
            end
         end
         default: f.count = 2'd0;
      endcase
      return f;
   endfunction

   function automatic logic [CharBits-1:0] clean_sep(input logic [7:0] s);
      logic alnum;
      alnum = (s >= 8'h61 && s <= 8'h7A) || (s >= 8'h41 && s <= 8'h5A) ||
              (s >= 8'h30 && s <= 8'h39);
      if (alnum || s < 8'h21 || s > 8'h7E) begin
         return SepDefault;
      end
      return s[CharBits-1:0];
   endfunction

endpackage

// ===== hw/rtl/utf8_slug_generator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_slug_generator_top
// Streams utf8 bytes in and emits ascii slug characters with running length.
// ----------------------------------------------------------------------------
// output: first result of an item is shown in the cycle after it is accepted
// throughput: one item per cycle while each item yields at most one result
//   and the result side is ready; an item with more results holds the input
//   off while the result buffer drains one result per cycle with rsp_tready high
// reset: synchronous; clears stream state, length counter and result count,
//   separator returns to '-' and upper case lowering is switched on
module utf8_slug_generator_top #(
   parameter int LENGTH_BITS = utf8s_pkg::LengthBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] out_char, [30:7] slug_length, [31] zero
   output logic        rsp_tuser,   // has_char
   output logic        rsp_tlast,   // end_of_slug
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int SumBits  = LENGTH_BITS + 2;
   localparam int WideBits = (LENGTH_BITS > utf8s_pkg::SlugLenBits) ?
                             LENGTH_BITS : utf8s_pkg::SlugLenBits;
   localparam int Slots    = utf8s_pkg::ResultSlots;

   utf8s_pkg::stream_state_type state_ff, state_in, dec_state;
   utf8s_pkg::dec_result_type   dec_res;

   logic [7:0]             sep_ff, sep_in;
   logic                   fold_ff, fold_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [1:0]             cnt_ff, cnt_in;

   logic [6:0]  char_ff [Slots];
   logic [6:0]  char_in [Slots];
   logic        has_ff  [Slots];
   logic        has_in  [Slots];
   logic [23:0] len_ff  [Slots];
   logic [23:0] len_in  [Slots];
   logic        end_ff  [Slots];
   logic        end_in  [Slots];

   logic [SumBits-1:0]     sum  [Slots];
   logic [LENGTH_BITS-1:0] sat  [Slots];
   logic [WideBits-1:0]    wide [Slots];
   logic [WideBits-1:0]    count_wide;
   logic [1:0]             nres;
   logic [1:0]             nchar_m1;
   logic                   accept;
   logic                   pop;

   utf8s_decode u_decode (
      .cur      (state_ff),
      .in_byte  (req_tdata),
      .sep_cfg  (sep_ff),
      .fold_cfg (fold_ff),
      .count_nz (count_ff != '0),
      .nxt      (dec_state),
      .res      (dec_res)
   );

   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {1'b0, len_ff[0], char_ff[0]};
   assign rsp_tuser  = has_ff[0];
   assign rsp_tlast  = end_ff[0];

   assign count_wide = WideBits'(count_ff);
   assign nres       = (dec_res.nchar == 2'd0 && req_tlast) ? 2'd1 : dec_res.nchar;
   assign nchar_m1   = dec_res.nchar - 2'd1;

   // saturating length for each result slot
   always_comb begin
      for (int k = 0; k < Slots; k++) begin
         sum[k]  = SumBits'(count_ff) + SumBits'(k + 1);
         sat[k]  = (|sum[k][SumBits-1:LENGTH_BITS]) ? '1 : sum[k][LENGTH_BITS-1:0];
         wide[k] = WideBits'(sat[k]);
      end
   end

   always_comb begin
      sep_in   = sep_ff;
      fold_in  = fold_ff;
      state_in = state_ff;
      count_in = count_ff;
      cnt_in   = cnt_ff;
      for (int k = 0; k < Slots; k++) begin
         char_in[k] = char_ff[k];
         has_in[k]  = has_ff[k];
         len_in[k]  = len_ff[k];
         end_in[k]  = end_ff[k];
      end

      if (csr_we) begin
         if (csr_index == utf8s_pkg::CSR_SEPARATOR) begin
            sep_in = csr_wdata;
         end else begin
            fold_in = csr_wdata[0];
         end
      end

      if (accept) begin
         cnt_in = nres;
         for (int k = 0; k < Slots; k++) begin
            has_in[k]  = (2'(k) < dec_res.nchar);
            char_in[k] = has_in[k] ? dec_res.chars[k] : 7'h00;
            len_in[k]  = (dec_res.nchar == 2'd0) ? count_wide[23:0] : wide[k][23:0];
            end_in[k]  = req_tlast && (2'(k) == nres - 2'd1);
         end
         if (req_tlast) begin
            state_in = '0;
            count_in = '0;
         end else begin
            state_in = dec_state;
            if (dec_res.nchar != 2'd0) begin
               count_in = sat[nchar_m1];
            end
         end
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         for (int k = 0; k < Slots - 1; k++) begin
            char_in[k] = char_ff[k+1];
            has_in[k]  = has_ff[k+1];
            len_in[k]  = len_ff[k+1];
            end_in[k]  = end_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff   <= utf8s_pkg::SepReset;
         fold_ff  <= 1'b1;
         state_ff <= '0;
         count_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         sep_ff   <= sep_in;
         fold_ff  <= fold_in;
         state_ff <= state_in;
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Slots; k++) begin
         char_ff[k] <= char_in[k];
         has_ff[k]  <= has_in[k];
         len_ff[k]  <= len_in[k];
         end_ff[k]  <= end_in[k];
      end
   end

endmodule

// ===== hw/rtl/utf8s_decode.sv =====
// ----------------------------------------------------------------------------
// utf8s_decode
// Decodes one input byte against the utf8 stream state: validation, latin-1
// folding, separator handling. Gives the next state and the characters due.
// ----------------------------------------------------------------------------
module utf8s_decode (
   input  utf8s_pkg::stream_state_type cur,
   input  logic [7:0]                  in_byte,
   input  logic [7:0]                  sep_cfg,
   input  logic                        fold_cfg,
   input  logic                        count_nz,
   output utf8s_pkg::stream_state_type nxt,
   output utf8s_pkg::dec_result_type   res
);

   utf8s_pkg::fold_type fold;
   logic                cont_ok;
   logic                mark;
   logic                do_lead;
   logic                pend_eff;
   logic                sep_emit;
   logic [1:0]          nword;
   logic [6:0]          w1;
   logic [6:0]          w2;

   assign fold = utf8s_pkg::fold_latin1(in_byte[5:0]);

   always_comb begin
      cont_ok = (in_byte[7:6] == 2'b10);
      if (cur.seen == 2'd0) begin
         if (cur.lead == utf8s_pkg::LeadE0 && in_byte < utf8s_pkg::ContA0) cont_ok = 1'b0;
         if (cur.lead == utf8s_pkg::LeadEd && in_byte >= utf8s_pkg::ContA0) cont_ok = 1'b0;
         if (cur.lead == utf8s_pkg::LeadF0 && in_byte < utf8s_pkg::Cont90) cont_ok = 1'b0;
         if (cur.lead == utf8s_pkg::LeadF4 && in_byte > utf8s_pkg::Cont8f) cont_ok = 1'b0;
      end
   end

   always_comb begin
      nxt     = cur;
      mark    = 1'b0;
      do_lead = 1'b0;
      nword   = 2'd0;
      w1      = 7'h00;
      w2      = 7'h00;
      if (cur.expect_cnt != 2'd0) begin
         if (cont_ok) begin
            nxt.seen       = cur.seen + 2'd1;
            nxt.expect_cnt = cur.expect_cnt - 2'd1;
            if (cur.expect_cnt == 2'd1) begin
               if (cur.lead == utf8s_pkg::LeadLatin1 && fold.count != 2'd0) begin
                  nword = fold.count;
                  w1    = fold.c0;
                  w2    = fold.c1;
               end else begin
                  mark = 1'b1;
               end
            end
         end else begin
            mark           = 1'b1;
            nxt.expect_cnt = 2'd0;
            nxt.seen       = 2'd0;
            do_lead        = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         if (!in_byte[7]) begin
            if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
               nword = 2'd1;
               w1    = fold_cfg ? in_byte[6:0] + 7'd32 : in_byte[6:0];
            end else if ((in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                         (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
               nword = 2'd1;
               w1    = in_byte[6:0];
            end else begin
               mark = 1'b1;
            end
         end else if (in_byte < utf8s_pkg::LeadMin || in_byte > utf8s_pkg::LeadMax) begin
            mark = 1'b1;
         end else begin
            nxt.lead = in_byte;
            nxt.seen = 2'd0;
            if (in_byte < utf8s_pkg::Lead3Min) begin
               nxt.expect_cnt = 2'd1;
            end else if (in_byte < utf8s_pkg::Lead4Min) begin
               nxt.expect_cnt = 2'd2;
            end else begin
               nxt.expect_cnt = 2'd3;
            end
         end
      end

      pend_eff    = cur.pending | (mark & count_nz);
      sep_emit    = (nword != 2'd0) && pend_eff;
      nxt.pending = (nword != 2'd0) ? 1'b0 : pend_eff;

      if (sep_emit) begin
         res.chars[0] = utf8s_pkg::clean_sep(sep_cfg);
         res.chars[1] = w1;
         res.chars[2] = w2;
         res.nchar    = nword + 2'd1;
      end else begin
         res.chars[0] = w1;
         res.chars[1] = w2;
         res.chars[2] = 7'h00;
         res.nchar    = nword;
      end
   end

endmodule

// ===== hw/rtl/utf8s_checker.sv =====
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level checks for the utf8 slug generator, bound to the top level.
// ----------------------------------------------------------------------------
module utf8s_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // result buffer comes up empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // input is never held off while the result buffer is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result buffer");

   // an end-only marker carries no character and closes the slug
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[6:0] == 7'h00))
      else $error("bad end-only marker");

   // a slug character is never a space or a control code below it
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[6:0] > 7'h20)
      else $error("emitted character out of range");

endmodule

bind utf8_slug_generator_top utf8s_checker u_utf8s_checker (.*);

// ===== verif/tb_utf8_slug_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_slug_generator_top
// Self-checking bench for the utf8 slug generator. Byte strings go in on the
// request stream and every slug result is checked against a slug predictor
// kept inside the bench. Directed strings cover ascii, latin-1 folding and
// malformed utf8. Random text then runs under several separator and case
// settings, random idling on both sides, an output stall and a steady run.
// ----------------------------------------------------------------------------
module tb_utf8_slug_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit   = 2000;
   localparam int EndLimit     = 1500;
   localparam int SettleCycles = 4;
   localparam int HoldCycles   = 64;
   localparam int IdlePct      = 24;

   typedef struct packed {
      logic [6:0]  ch;
      logic        has;
      logic [23:0] len;
      logic        eos;
   } slug_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [6:0] out_char, [30:7] slug_length, [31] zero
   logic        rsp_tuser;   // has_char
   logic        rsp_tlast;   // end_of_slug
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [7:0]  csr_wdata;

   utf8_slug_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   logic [7:0]   sep_reg  = utf8s_pkg::SepReset;
   logic         fold_reg = 1'b1;
   logic [7:0]   seq_lead = '0;
   logic [1:0]   seq_left = '0;
   logic [1:0]   seq_seen = '0;
   logic         sep_pending = 1'b0;
   logic [23:0]  char_count = '0;
   slug_out_type step_outs[$];
   slug_out_type expected_chars[$];
   logic [7:0]   text_bytes[$];

   int mismatches      = 0;
   int items_sent      = 0;
   int strings_sent    = 0;
   int results_checked = 0;
   int settings_used   = 1;
   int quiet_cycles    = 0;
   int hold_asked      = 0;
   int hold_done       = 0;
   bit tx_steady       = 1'b0;
   bit rx_steady       = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // slug predictor

   function automatic logic ascii_alnum(input logic [7:0] b);
      return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [6:0] usable_sep(input logic [7:0] s);
      if (ascii_alnum(s) || s < 8'h21 || s > 8'h7E) begin
         return utf8s_pkg::SepDefault;
      end
      return s[6:0];
   endfunction

   function automatic string latin1_letters(input logic [5:0] idx);
      logic [4:0] k;
      k = idx[4:0];
      if (k <= 5'd5) return "a";
      if (k == 5'd6) return "ae";
      if (k == 5'd7) return "c";
      if (k <= 5'd11) return "e";
      if (k <= 5'd15) return "i";
      if (k == 5'd16) return "d";
      if (k == 5'd17) return "n";
      if (k == 5'd23) return "";
      if (k <= 5'd24) return "o";
      if (k <= 5'd28) return "u";
      if (k == 5'd29) return "y";
      if (k == 5'd30) return "th";
      if (idx[5]) return "y";
      return "ss";
   endfunction

   function automatic void push_char(input logic [6:0] ch, input logic has);
      slug_out_type r;
      if (has && char_count != '1) char_count = char_count + 24'd1;
      r.ch  = has ? ch : 7'd0;
      r.has = has;
      r.len = char_count;
      r.eos = 1'b0;
      step_outs.push_back(r);
   endfunction

   function automatic void note_break();
      if (char_count != 0) sep_pending = 1'b1;
   endfunction

   function automatic void word_letter(input logic [6:0] ch);
      if (sep_pending && char_count != 0) push_char(usable_sep(sep_reg), 1'b1);
      sep_pending = 1'b0;
      push_char(ch, 1'b1);
   endfunction

   function automatic void start_lead(input logic [7:0] b);
      if (b < 8'h80) begin
         if (!ascii_alnum(b)) begin
            note_break();
         end else if (fold_reg && b inside {[8'h41:8'h5A]}) begin
            word_letter(b[6:0] | 7'h20);
         end else begin
            word_letter(b[6:0]);
         end
      end else if (b < utf8s_pkg::LeadMin || b > utf8s_pkg::LeadMax) begin
         note_break();
      end else begin
         seq_lead = b;
         seq_seen = 2'd0;
         seq_left = (b < utf8s_pkg::Lead3Min) ? 2'd1 :
                    ((b < utf8s_pkg::Lead4Min) ? 2'd2 : 2'd3);
      end
   endfunction

   function automatic logic cont_fits(input logic [7:0] b);
      if (b[7:6] != 2'b10) return 1'b0;
      if (seq_seen == 2'd0) begin
         if (seq_lead == utf8s_pkg::LeadE0 && b < utf8s_pkg::ContA0) return 1'b0;
         if (seq_lead == utf8s_pkg::LeadEd && b >= utf8s_pkg::ContA0) return 1'b0;
         if (seq_lead == utf8s_pkg::LeadF0 && b < utf8s_pkg::Cont90) return 1'b0;
         if (seq_lead == utf8s_pkg::LeadF4 && b > utf8s_pkg::Cont8f) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void close_sequence(input logic [7:0] b);
      string      f;
      logic [7:0] c;
      if (seq_lead != utf8s_pkg::LeadLatin1) begin
         note_break();
      end else begin
         f = latin1_letters(b[5:0]);
         if (f.len() == 0) begin
            note_break();
         end else begin
            for (int i = 0; i < f.len(); i++) begin
               c = f[i];
               word_letter(c[6:0]);
            end
         end
      end
   endfunction

   function automatic void step_slug(input logic [7:0] b, input logic last);
      step_outs.delete();
      if (seq_left != 0) begin
         if (cont_fits(b)) begin
            seq_seen = seq_seen + 2'd1;
            seq_left = seq_left - 2'd1;
            if (seq_left == 0) close_sequence(b);
         end else begin
            note_break();
            seq_left = 2'd0;
            seq_seen = 2'd0;
            start_lead(b);
         end
      end else begin
         start_lead(b);
      end
      if (last) begin
         if (step_outs.size() == 0) push_char(7'd0, 1'b0);
         step_outs[step_outs.size() - 1].eos = 1'b1;
         seq_lead    = '0;
         seq_left    = '0;
         seq_seen    = '0;
         sep_pending = 1'b0;
         char_count  = '0;
      end
      foreach (step_outs[i]) expected_chars.push_back(step_outs[i]);
   endfunction

   // checking

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slug_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_chars.size() == 0) begin
            flag_mismatch("result with nothing expected", rsp_tdata, 32'd0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata[6:0] !== want.ch) begin
               flag_mismatch("out_char", 32'(rsp_tdata[6:0]), 32'(want.ch));
            end
            if (rsp_tuser !== want.has) begin
               flag_mismatch("has_char", 32'(rsp_tuser), 32'(want.has));
            end
            if (rsp_tdata[30:7] !== want.len) begin
               flag_mismatch("slug_length", 32'(rsp_tdata[30:7]), 32'(want.len));
            end
            if (rsp_tlast !== want.eos) begin
               flag_mismatch("end_of_slug", 32'(rsp_tlast), 32'(want.eos));
            end
            if (rsp_tdata[31] !== 1'b0) begin
               flag_mismatch("tdata pad bit", 32'(rsp_tdata[31]), 32'd0);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t no item moved for %0d cycles", $time, QuietLimit);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls plus a counted hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_done < hold_asked) begin
            hold_done++;
            rsp_tready <= 1'b0;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // stimulus helpers

   task automatic offer_byte(input logic [7:0] b, input logic last);
      while (!tx_steady && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_slug(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_string();
      foreach (text_bytes[i]) offer_byte(text_bytes[i], i == text_bytes.size() - 1);
      strings_sent++;
      text_bytes.delete();
   endtask

   task automatic drain_results(input int extra);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input utf8s_pkg::csr_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         utf8s_pkg::CSR_SEPARATOR:  sep_reg  = value;
         utf8s_pkg::CSR_LOWER_CASE: fold_reg = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic void append_token();
      int         pick;
      logic [7:0] lead;
      pick = $urandom_range(99);
      if (pick < 25) begin
         case ($urandom_range(2))
            0: text_bytes.push_back(rand_byte(8'h41, 8'h5A));
            1: text_bytes.push_back(rand_byte(8'h61, 8'h7A));
            default: text_bytes.push_back(rand_byte(8'h30, 8'h39));
         endcase
      end else if (pick < 35) begin
         text_bytes.push_back(rand_byte(8'h00, 8'h7F));
      end else if (pick < 55) begin
         text_bytes.push_back(utf8s_pkg::LeadLatin1);
         text_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end else if (pick < 65) begin
         text_bytes.push_back(rand_byte(8'hC2, 8'hDF));
         text_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end else if (pick < 73) begin
         lead = rand_byte(8'hE0, 8'hEF);
         text_bytes.push_back(lead);
         if (lead == utf8s_pkg::LeadE0) text_bytes.push_back(rand_byte(8'hA0, 8'hBF));
         else if (lead == utf8s_pkg::LeadEd) text_bytes.push_back(rand_byte(8'h80, 8'h9F));
         else text_bytes.push_back(rand_byte(8'h80, 8'hBF));
         text_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end else if (pick < 80) begin
         lead = rand_byte(8'hF0, 8'hF4);
         text_bytes.push_back(lead);
         if (lead == utf8s_pkg::LeadF0) text_bytes.push_back(rand_byte(8'h90, 8'hBF));
         else if (lead == utf8s_pkg::LeadF4) text_bytes.push_back(rand_byte(8'h80, 8'h8F));
         else text_bytes.push_back(rand_byte(8'h80, 8'hBF));
         text_bytes.push_back(rand_byte(8'h80, 8'hBF));
         text_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end else if (pick < 90) begin
         // lead followed by an arbitrary byte, mostly a broken sequence
         text_bytes.push_back(rand_byte(8'hC2, 8'hF4));
         text_bytes.push_back(rand_byte(8'h00, 8'hFF));
      end else begin
         text_bytes.push_back(rand_byte(8'h00, 8'hFF));
      end
   endfunction

   task automatic send_random_text(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         repeat ($urandom_range(6, 1)) append_token();
         sent += text_bytes.size();
         send_string();
      end
   endtask

   // tests

   task automatic test_ascii_edges();
      drain_results(SettleCycles);
      text_bytes = '{8'h00, 8'h5A, 8'h61, 8'h39, 8'h7F};
      send_string();
      text_bytes = '{8'hFF};
      send_string();
   endtask

   task automatic test_latin1_folds();
      drain_results(SettleCycles);
      text_bytes = '{8'hC3, 8'h86, 8'hC3, 8'h97, 8'hC3, 8'h9E};
      send_string();
   endtask

   task automatic test_malformed_input();
      drain_results(SettleCycles);
      text_bytes = '{8'h71, 8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90, 8'hF0, 8'h8F,
                     8'hC4, 8'h80, 8'hC3, 8'h4B, 8'hE2};
      send_string();
   endtask

   task automatic test_register_sweep();
      logic [7:0] seps [7];
      seps = '{8'h00, 8'hFF, 8'h21, 8'h7E, 8'h7A, 8'h5F, rand_byte(8'h00, 8'hFF)};
      for (int i = 0; i < 7; i++) begin
         drain_results(SettleCycles);
         write_reg(utf8s_pkg::CSR_SEPARATOR, seps[i]);
         write_reg(utf8s_pkg::CSR_LOWER_CASE, {7'd0, i[0]});
         settings_used++;
         send_random_text(8);
      end
   endtask

   task automatic test_output_backpressure();
      logic [7:0] twin [5];
      twin = '{8'h86, 8'h9E, 8'h9F, 8'hA6, 8'hBE};
      drain_results(SettleCycles);
      tx_steady = 1'b1;
      @(posedge clock);
      hold_asked = hold_asked + HoldCycles;
      @(negedge clock);
      text_bytes.push_back(8'h78);
      repeat (6) begin
         text_bytes.push_back(8'h2E);
         text_bytes.push_back(utf8s_pkg::LeadLatin1);
         text_bytes.push_back(twin[$urandom_range(4)]);
      end
      send_string();
      while (hold_done < hold_asked) @(negedge clock);
      tx_steady = 1'b0;
   endtask

   task automatic test_steady_stream();
      drain_results(SettleCycles);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      send_random_text(30);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   initial begin
      int waited;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = utf8s_pkg::CSR_SEPARATOR;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ascii_edges();
      test_latin1_folds();
      test_malformed_input();
      test_register_sweep();
      test_output_backpressure();
      test_steady_stream();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_chars.size() != 0 && waited < EndLimit) begin
         @(negedge clock);
         waited++;
      end
      repeat (2 * SettleCycles) @(negedge clock);
      if (expected_chars.size() != 0) begin
         flag_mismatch("results never delivered", 32'(expected_chars.size()), 32'd0);
      end

      $display("covered %0d bytes in %0d strings under %0d register settings",
               items_sent, strings_sent, settings_used);
      $display("compared %0d slug results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/utf8s_pkg.sv
hw/rtl/utf8s_decode.sv
hw/rtl/utf8_slug_generator_top.sv
hw/rtl/utf8s_checker.sv
verif/tb_utf8_slug_generator_top.sv
